/* rtl/nac_pkg.sv */
// Package for the nibble accumulator execute block.
// Holds opcodes, field widths, status masks, the architectural state struct and the flags struct.
// No dependencies.
package nac_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int OP_W          = 3;
    localparam int NIB_W         = 4;
    localparam int FIELD_ADDR_W  = 12;
    localparam int PINS_W        = 12;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 48;
    localparam int MIRROR_LAST   = 2;

    localparam logic [NIB_W-1:0] HALT_MASK   = 4'h2;
    localparam logic [NIB_W-1:0] KEEP_MASK   = 4'h6;
    localparam logic [NIB_W-1:0] SIGN_MASK   = 4'h8;

    typedef enum logic [OP_W-1:0] {
        OP_HLT = 3'd0,
        OP_LOD = 3'd1,
        OP_STR = 3'd2,
        OP_ADD = 3'd3,
        OP_NOP = 3'd4,
        OP_NND = 3'd5,
        OP_JMP = 3'd6,
        OP_CXA = 3'd7
    } t_op;

    typedef struct packed {
        logic [NIB_W-1:0] acc;
        logic [NIB_W-1:0] status;
        logic [NIB_W-1:0] mir0;
        logic [NIB_W-1:0] mir1;
        logic [NIB_W-1:0] mir2;
    } t_core;

    typedef struct packed {
        logic jump_taken;
        logic gpio_write;
        logic mem_we;
    } t_flags;

endpackage

/* rtl/nibble_accumulator_cpu_execute.sv */
// Top level of the nibble accumulator execute block.
// Holds the nibble memory, pipeline registers and result register.
// Depends on nac_pkg and nac_exec.
//
// Usage:
//   Slave channel (i_s_*) takes one instruction request per handshake:
//   opcode, nibble address and the sampled GPIO pins. Master channel (o_m_*)
//   returns one result per instruction: accumulator, status, program counter,
//   jump flag, memory address register and the GPIO drive.
//   The accepting edge loads the execute stage and reads the nibble memory
//   synchronously; the execute stage then executes and loads the result
//   register, which drives o_m_tvalid. Throughput is one instruction per cycle
//   while the receiver does not stall; a store's write is forwarded to a read
//   of the same address in the next request. Nibbles 0..2 mirror the pins in
//   registers; their reads take the pins, not the memory. After reset the block
//   sweeps the memory to zero, one nibble per cycle, holding o_s_tready low.
//   When the receiver stalls, the result register holds, the execute stage
//   holds behind it, and o_s_tready drops once both are full.
module nibble_accumulator_cpu_execute #(
    parameter int ADDR_BITS = nac_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [2:0] operation, [14:3] address, [26:15] gpio_in, [31:27] zero
    input  logic [nac_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [3:0] accumulator, [7:4] status, [19:8] program_counter, [20] jump_taken,
    // [32:21] last_address, [33] gpio_write, [45:34] gpio_out, [47:46] zero
    output logic [nac_pkg::M_DATA_W-1:0]   o_m_tdata
);

    localparam int AW    = ADDR_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = nac_pkg::NIB_W;
    localparam int FW    = nac_pkg::FIELD_ADDR_W;
    localparam int PW    = nac_pkg::PINS_W;

    // Input decode
    nac_pkg::t_op       w_in_op;
    logic [AW-1:0]      w_in_addr;
    logic [PW-1:0]      w_in_pins;

    assign w_in_op   = nac_pkg::t_op'(i_s_tdata[2:0]);
    assign w_in_addr = AW'(i_s_tdata[14:3]);
    assign w_in_pins = i_s_tdata[26:15];

    // Clearing sweep
    logic               r_clearing;
    logic [AW-1:0]      r_clr_cnt;

    // Execute stage
    logic               r_ex_valid;
    nac_pkg::t_op       r_ex_op;
    logic [AW-1:0]      r_ex_addr;
    logic [PW-1:0]      r_ex_pins;
    logic [NW-1:0]      r_rdata;

    // Architectural state
    nac_pkg::t_core     r_core;
    logic [AW-1:0]      r_pc;
    logic [AW-1:0]      r_areg;

    // Result register
    logic               r_out_valid;
    logic [NW-1:0]      r_out_acc;
    logic [NW-1:0]      r_out_status;
    logic [FW-1:0]      r_out_pc;
    logic               r_out_jump;
    logic [FW-1:0]      r_out_last;
    logic               r_out_gw;
    logic [PW-1:0]      r_out_gpio;

    logic [NW-1:0]      r_mem [DEPTH];

    nac_pkg::t_core     n_core;
    logic [AW-1:0]      n_pc;
    logic [AW-1:0]      n_areg;
    nac_pkg::t_flags    w_flags;
    logic [PW-1:0]      w_gpio_out;

    logic               w_advance;
    logic               w_accept;
    logic               w_ex_we;
    logic               w_fwd;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [NW-1:0]      w_mem_wdata;

    nac_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .i_op       (r_ex_op),
        .i_addr     (r_ex_addr),
        .i_pins     (r_ex_pins),
        .i_rdata    (r_rdata),
        .i_core     (r_core),
        .i_pc       (r_pc),
        .i_areg     (r_areg),
        .o_core     (n_core),
        .o_pc       (n_pc),
        .o_areg     (n_areg),
        .o_flags    (w_flags),
        .o_gpio_out (w_gpio_out)
    );

    assign w_advance  = r_ex_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clearing && (!r_ex_valid || w_advance);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_ex_we    = w_advance && w_flags.mem_we;
    // Forward a store to a read of the same address issued in the same cycle
    assign w_fwd      = w_ex_we && (r_ex_addr == w_in_addr);

    assign w_mem_we    = r_clearing || w_ex_we;
    assign w_mem_waddr = r_clearing ? r_clr_cnt : r_ex_addr;
    assign w_mem_wdata = r_clearing ? '0 : r_core.acc;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_accept) begin
            r_rdata <= w_fwd ? w_mem_wdata : r_mem[w_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (&r_clr_cnt) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
        end else if (w_accept) begin
            r_ex_valid <= 1'b1;
        end else if (w_advance) begin
            r_ex_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ex_op   <= w_in_op;
            r_ex_addr <= w_in_addr;
            r_ex_pins <= w_in_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
            r_pc   <= '0;
            r_areg <= '0;
        end else if (w_advance) begin
            r_core <= n_core;
            r_pc   <= n_pc;
            r_areg <= n_areg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_acc    <= n_core.acc;
            r_out_status <= n_core.status;
            r_out_pc     <= FW'(n_pc);
            r_out_jump   <= w_flags.jump_taken;
            r_out_last   <= FW'(n_areg);
            r_out_gw     <= w_flags.gpio_write;
            r_out_gpio   <= w_gpio_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_gpio, r_out_gw, r_out_last, r_out_jump,
                         r_out_pc, r_out_status, r_out_acc};

`ifndef NO_ASSERTIONS
    a_stall_holds_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_advance)
        else $error("execute stage advanced into a stalled result register");

    a_jump_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_jump) |-> (r_out_pc == r_out_last))
        else $error("taken jump result has pc different from address register");

    a_gpio_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_gw) |-> (r_out_gpio == '0))
        else $error("gpio_out nonzero without a pin write");

    a_fwd_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fwd |-> (r_ex_op == nac_pkg::OP_STR && !r_clearing))
        else $error("memory forward without a store in execute");
`endif

endmodule

/* rtl/nac_exec.sv */
// Combinational execute logic for one instruction of the accumulator machine.
// Takes the current state and registered memory data, gives next state and flags.
// Depends on nac_pkg.
module nac_exec #(
    parameter int ADDR_BITS = nac_pkg::ADDR_BITS_DEF
) (
    input  nac_pkg::t_op                  i_op,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [nac_pkg::PINS_W-1:0]    i_pins,
    input  logic [nac_pkg::NIB_W-1:0]     i_rdata,
    input  nac_pkg::t_core                i_core,
    input  logic [ADDR_BITS-1:0]          i_pc,
    input  logic [ADDR_BITS-1:0]          i_areg,
    output nac_pkg::t_core                o_core,
    output logic [ADDR_BITS-1:0]          o_pc,
    output logic [ADDR_BITS-1:0]          o_areg,
    output nac_pkg::t_flags               o_flags,
    output logic [nac_pkg::PINS_W-1:0]    o_gpio_out
);

    localparam int NW = nac_pkg::NIB_W;

    logic              w_mirror;
    logic [NW-1:0]     w_pin_nib;
    logic [NW-1:0]     w_m;
    logic [NW:0]       w_sum;
    logic              w_ovf;
    nac_pkg::t_core    w_core;

    assign w_mirror = (i_addr <= ADDR_BITS'(nac_pkg::MIRROR_LAST));

    always_comb begin
        unique case (i_addr[1:0])
            2'd0:    w_pin_nib = i_pins[11:8];
            2'd1:    w_pin_nib = i_pins[7:4];
            default: w_pin_nib = i_pins[3:0];
        endcase
    end

    // Mirror nibbles read straight from the pins
    assign w_m   = w_mirror ? w_pin_nib : i_rdata;
    assign w_sum = {1'b0, i_core.acc} + {1'b0, w_m};
    assign w_ovf = |(~(i_core.acc ^ w_m) & (i_core.acc ^ w_sum[NW-1:0]) & nac_pkg::SIGN_MASK);

    always_comb begin
        w_core     = i_core;
        o_pc       = i_pc;
        o_areg     = i_areg;
        o_flags    = '0;
        o_gpio_out = '0;
        unique case (i_op)
            nac_pkg::OP_HLT: begin
                w_core.status = i_core.status | nac_pkg::HALT_MASK;
            end
            nac_pkg::OP_LOD: begin
                o_areg     = i_addr;
                w_core.acc = w_m;
            end
            nac_pkg::OP_STR: begin
                o_areg         = i_addr;
                o_flags.mem_we = 1'b1;
                if (w_mirror) begin
                    unique case (i_addr[1:0])
                        2'd0:    w_core.mir0 = i_core.acc;
                        2'd1:    w_core.mir1 = i_core.acc;
                        default: w_core.mir2 = i_core.acc;
                    endcase
                    o_flags.gpio_write = 1'b1;
                    o_gpio_out = {w_core.mir0, w_core.mir1, w_core.mir2};
                end
            end
            nac_pkg::OP_ADD: begin
                o_areg        = i_addr;
                w_core.acc    = w_sum[NW-1:0];
                w_core.status = (i_core.status & nac_pkg::KEEP_MASK)
                              | {w_ovf ^ w_sum[NW-1], 2'b00, w_sum[NW]};
            end
            nac_pkg::OP_NOP: begin
            end
            nac_pkg::OP_NND: begin
                o_areg     = i_addr;
                w_core.acc = ~(i_core.acc & w_m);
            end
            nac_pkg::OP_JMP: begin
                o_areg = i_addr;
                if (i_core.acc == '0) begin
                    o_pc               = i_addr;
                    o_flags.jump_taken = 1'b1;
                end
            end
            nac_pkg::OP_CXA: begin
                w_core.acc = i_core.status;
            end
            default: begin
            end
        endcase
        // Refresh the mirrors from the pins on read-type operations
        if (w_mirror && (i_op == nac_pkg::OP_LOD || i_op == nac_pkg::OP_ADD ||
                         i_op == nac_pkg::OP_NND || i_op == nac_pkg::OP_JMP)) begin
            w_core.mir0 = i_pins[11:8];
            w_core.mir1 = i_pins[7:4];
            w_core.mir2 = i_pins[3:0];
        end
    end

    assign o_core = w_core;

endmodule
